// ----- hdl/sidta_pkg.sv -----
// ----------------------------------------------------------------------------
// sidta_pkg: shared types and constants
// Character codes, default widths, the sequencer state type and the bcd
// digit correction for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // default width of the signed input value
  localparam int VALUE_WIDTH_DEF = 32;

  // width of one ascii character code on the result side
  localparam int CHAR_WIDTH = 6;

  // character codes
  localparam logic [CHAR_WIDTH-1:0] CODE_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CODE_MINUS = 6'd45;

  // bcd digit width
  localparam int DIGIT_WIDTH = 4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_EMIT
  } sidta_state_t;

  // bcd digit correction ahead of a left shift (add three when five or more)
  function automatic logic [DIGIT_WIDTH-1:0] bcd_adjust(input logic [DIGIT_WIDTH-1:0] d);
    logic [DIGIT_WIDTH-1:0] res;
    res = (d >= 4'd5) ? (d + 4'd3) : d;
    return res;
  endfunction

endpackage

// ----- hdl/sidta_bcd_step.sv -----
// ----------------------------------------------------------------------------
// sidta_bcd_step: one shift-add-three step
// Corrects every bcd digit and shifts one new binary bit in at the bottom.
// Used once per cycle by the sequencer in the top level.
// ----------------------------------------------------------------------------
module sidta_bcd_step
  import sidta_pkg::*;
#(
  parameter int NDIG = 10
) (
  input  logic [NDIG*DIGIT_WIDTH-1:0] bcd_in,
  input  logic                        bit_in,
  output logic [NDIG*DIGIT_WIDTH-1:0] bcd_out
);

  logic [NDIG*DIGIT_WIDTH-1:0] adj;

  // per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_adjust(bcd_in[i*DIGIT_WIDTH +: DIGIT_WIDTH]);
    end
  end

  // shift the new bit in
  assign bcd_out = {adj[NDIG*DIGIT_WIDTH-2:0], bit_in};

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ascii text
// Converts one signed value into its decimal characters, most significant
// digit first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries one signed value in in_tdata (low bits).
//   out_* : one transaction per character; out_tdata[5:0] is the ascii code
//           (45 minus, 48..57 digits), out_tlast marks the last character.
// Sequence (VALUE_WIDTH = W, NDIG = decimal digits of 2^(W-1)):
//   load and negate, shift-add-three through the single bcd step unit
//   for each of the W bits, skipping of leading zeros, then the minus
//   sign for a negative value and the digits, each character held until
//   it is taken while out_tready is high.
//   in_tready is high only while the converter is idle, one item at a time.
// Reset: synchronous active-low rst_n returns the sequencer to idle and drops
//   out_tvalid; no character in progress survives it.
// Stall: a character holds on the output while out_tready is low and the
//   sequence resumes when it is taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sidta_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [5:0] char_code, [7:6] zero
  output logic                               out_tlast   // is_last
);

  localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCDW = NDIG * DIGIT_WIDTH;
  localparam int BW   = $clog2(VALUE_WIDTH + 1);
  localparam int DW   = $clog2(NDIG + 1);

  sidta_state_t           state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BCDW-1:0]        bcd_r, bcd_nxt;
  logic [BCDW-1:0]        bcd_step;
  logic [BW-1:0]          bit_cnt_r, bit_cnt_nxt;
  logic [DW-1:0]          dig_cnt_r, dig_cnt_nxt;

  logic [VALUE_WIDTH-1:0]  raw;
  logic [DIGIT_WIDTH-1:0]  top_digit;
  logic                    in_fire, out_fire;
  logic                    top_zero;

  assign raw       = in_tdata[VALUE_WIDTH-1:0];
  assign top_digit = bcd_r[BCDW-1 -: DIGIT_WIDTH];
  assign top_zero  = (top_digit == '0) && (dig_cnt_r > DW'(1));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // shared shift-add-three unit
  sidta_bcd_step #(
    .NDIG (NDIG)
  ) u_step (
    .bcd_in  (bcd_r),
    .bit_in  (mag_r[VALUE_WIDTH-1]),
    .bcd_out (bcd_step)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == BW'(1)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!top_zero) state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_tready) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready && (dig_cnt_r == DW'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and character outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    out_tdata  = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SIGN: begin
        out_tvalid = 1'b1;
        out_tdata  = {2'b00, CODE_MINUS};
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tdata  = {2'b00, CODE_ZERO + {2'b00, top_digit}};
        out_tlast  = (dig_cnt_r == DW'(1));
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          neg_nxt     = raw[VALUE_WIDTH-1];
          mag_nxt     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
          bcd_nxt     = '0;
          bit_cnt_nxt = BW'(VALUE_WIDTH);
          dig_cnt_nxt = DW'(NDIG);
        end
      end
      ST_CONV: begin
        bcd_nxt     = bcd_step;
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BW'(1);
      end
      ST_SCAN: begin
        if (top_zero) begin
          bcd_nxt     = {bcd_r[BCDW-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
          dig_cnt_nxt = dig_cnt_r - DW'(1);
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          bcd_nxt     = {bcd_r[BCDW-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
          dig_cnt_nxt = dig_cnt_r - DW'(1);
        end
      end
      default: begin
        bcd_nxt = bcd_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
  end

  // an accepted value always starts the conversion
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CONV))
    else $error("conversion did not start after input transaction");

  // the minus sign only appears for negative values
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> neg_r)
    else $error("minus sign for a non-negative value");

  // digit count never runs out while characters are emitted
  a_dig_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (dig_cnt_r != '0))
    else $error("digit counter empty during emit");

  // no new input while characters are still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while output pending");

  // after the last character the block returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> in_tready)
    else $error("not idle after last character");

endmodule
